### rtl/stbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

    // Default table capacity and fixed field widths.
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_W         = 31;
    localparam int INDEX_W         = 10;
    localparam int S_TDATA_W       = 32;
    localparam int S_TUSER_W       = 2;
    localparam int M_TDATA_W       = 16;
    localparam int M_PAD_W         = M_TDATA_W - INDEX_W - 1;

    // Request kinds carried in the lowest tuser bit.
    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_en;
        logic start;
        logic issue_probe;
        logic step;
        logic finish_hit;
        logic finish_miss;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic range_empty;
        logic match;
        logic out_free;
    } ctrl_sts_t;

endpackage

`default_nettype wire

### rtl/stbs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/stbs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module stbs_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_op,
    output logic                    s_ready,
    input  wire stbs_pkg::ctrl_sts_t sts,
    output stbs_pkg::ctrl_cmd_t     cmd
);

    import stbs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_PROBE   = 4'b0010,
        ST_COMPARE = 4'b0100,
        ST_DONE    = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (op_t'(s_op) == OP_SEARCH) begin
                        cmd.start  = 1'b1;
                        state_next = ST_PROBE;
                    end else begin
                        cmd.load_en = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (sts.range_empty) begin
                    cmd.finish_miss = 1'b1;
                    state_next      = ST_DONE;
                end else begin
                    cmd.issue_probe = 1'b1;
                    state_next      = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                if (sts.match) begin
                    cmd.finish_hit = 1'b1;
                    state_next     = ST_DONE;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A compare always follows the probe that issued its read.
    a_compare_after_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMPARE) |-> $past(state_reg == ST_PROBE))
        else $error("compare state entered without a preceding probe");

    // A finished result waits while the output register is still occupied.
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !sts.out_free) |=> (state_reg == ST_DONE))
        else $error("result left done state while output was occupied");

    // An accepted search always starts with a range check.
    a_search_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_valid && s_op == OP_SEARCH) |=> (state_reg == ST_PROBE))
        else $error("accepted search did not start probing");

endmodule

`default_nettype wire

### rtl/stbs_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module stbs_dp #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        first_element,
    input  wire logic [stbs_pkg::VALUE_W-1:0] value,
    input  wire stbs_pkg::ctrl_cmd_t         cmd,
    output stbs_pkg::ctrl_sts_t              sts,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [stbs_pkg::M_TDATA_W-1:0]   m_data
);

    import stbs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [CW-1:0]        count_reg,  count_next;
    logic [CW-1:0]        low_reg,    low_next;
    logic [CW-1:0]        hi_reg,     hi_next;
    logic [AW-1:0]        mid_reg,    mid_next;
    logic [VALUE_W-1:0]   target_reg, target_next;
    logic                 hit_reg,    hit_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg,  m_data_next;

    logic [CW:0]          mid_sum;
    logic [CW-1:0]        mid_full;
    logic [AW-1:0]        mid_addr;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [VALUE_W-1:0]   ram_rdata;
    logic [AW+INDEX_W-1:0] mid_wide;
    logic [INDEX_W-1:0]   index_out;

    // Midpoint of the inclusive range [low, hi - 1]; low < hi when it is used.
    assign mid_sum  = {1'b0, low_reg} + {1'b0, hi_reg} - (CW + 1)'(1);
    assign mid_full = mid_sum[CW:1];
    assign mid_addr = mid_full[AW-1:0];

    assign ram_we    = cmd.load_en && (first_element || (count_reg != DEPTH_C));
    assign ram_waddr = first_element ? '0 : count_reg[AW-1:0];

    stbs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .raddr (mid_addr),
        .rdata (ram_rdata)
    );

    assign mid_wide  = {{INDEX_W{1'b0}}, mid_reg};
    assign index_out = hit_reg ? mid_wide[INDEX_W-1:0] : '0;

    always_comb begin
        count_next   = count_reg;
        low_next     = low_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        target_next  = target_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (cmd.load_en) begin
            if (first_element) begin
                count_next = CW'(1);
            end else if (count_reg != DEPTH_C) begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.start) begin
            low_next    = '0;
            hi_next     = count_reg;
            target_next = value;
        end
        if (cmd.issue_probe) begin
            mid_next = mid_addr;
        end
        if (cmd.step) begin
            if (ram_rdata < target_reg) begin
                low_next = CW'(mid_reg) + CW'(1);
            end else begin
                hi_next = CW'(mid_reg);
            end
        end
        if (cmd.finish_hit) begin
            hit_next = 1'b1;
        end
        if (cmd.finish_miss) begin
            hit_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {{M_PAD_W{1'b0}}, index_out, hit_reg};
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        low_reg    <= low_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        target_reg <= target_next;
        hit_reg    <= hit_next;
        m_data_reg <= m_data_next;
    end

    assign sts.range_empty = !(low_reg < hi_reg);
    assign sts.match       = (ram_rdata == target_reg);
    assign sts.out_free    = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The element count never passes the table capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("element count exceeds table capacity");

endmodule

`default_nettype wire

### rtl/sorted_table_binary_search_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted table with binary search.
// Requests arrive on the s_axis channel. tuser bit 0 selects the kind of request:
// 0 loads one table element, 1 searches for a target. On a load, tuser bit 1
// restarts the table at index zero; elements beyond the capacity are dropped.
// tdata carries the element or the target. A load gives no result; each search
// gives one result on the m_axis channel with a found flag and the matching
// index (zero when not found).
// A load is taken in the idle state. A search that misses takes the request,
// makes its probes, makes a final range check and then moves the answer into the
// output register. A search that hits skips the final range check. Each probe
// spans a probe state and a compare state, since each comparison must wait for
// the registered read of the table memory.
// With 1024 loaded entries a search makes at most 11 probes.
// One request is in work at a time; s_axis_tready is high only while idle.
// The output register holds a result until the receiver takes it, so a load
// or a new search can be accepted while that result waits; a second finished
// search waits for the register to drain when the receiver stalls.
// Reset clears the element count (empty table) and the output valid flag.
// The table memory itself is not cleared; only written entries are probed.
module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [30:0] value, [31] zero padding
    input  wire logic [stbs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] operation, [1] first_element
    input  wire logic [stbs_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [0] found, [10:1] index, [15:11] zero padding
    output logic [stbs_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    import stbs_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // The controller sequences loads, probes and result hand-off.
    stbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_op    (s_axis_tuser[0]),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the table memory, the search bounds and the output register.
    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .first_element (s_axis_tuser[1]),
        .value         (s_axis_tdata[VALUE_W-1:0]),
        .cmd           (cmd),
        .sts           (sts),
        .m_valid       (m_axis_tvalid),
        .m_ready       (m_axis_tready),
        .m_data        (m_axis_tdata)
    );

endmodule

`default_nettype wire

### tb/sorted_table_binary_search_unit_tb.sv
`timescale 1ns / 1ps

// Testbench for the sorted table binary search unit.
// Load requests build tables of mostly ascending values, with duplicates, wide and
// dense spreads, appends without a restart, and a few tables that are not sorted.
// Search requests aim at stored values, their neighbors, the extremes and random
// targets. A scoreboard class keeps its own copy of the table and the element count,
// repeats the search for every accepted search request, and compares each returned answer
// with the oldest one it still holds. Inputs change at the falling clock edge, and
// both channels are sampled at the rising edge.
module sorted_table_binary_search_unit_tb;

    import stbs_pkg::*;

    localparam int          DEPTH     = TABLE_DEPTH_DEF;
    localparam int unsigned VALUE_MAX = 32'h7FFF_FFFF;

    // One expected answer of a search, in the order of the result fields.
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
    } search_answer_t;

    // Shadow of the block's table and the answers it still owes.
    class search_scoreboard;
        logic [VALUE_W-1:0] elem_mem [DEPTH];
        int unsigned        elem_count;
        search_answer_t     pending_answers [$];
        int unsigned        mismatches;

        function new();
            elem_count = 0;
            mismatches = 0;
        endfunction

        // Binary search over the loaded elements, probing only written entries.
        function search_answer_t search_outcome(logic [VALUE_W-1:0] target);
            search_answer_t ans;
            int             lo;
            int             hi;
            int             mid;
            lo  = 0;
            hi  = int'(elem_count) - 1;
            ans = '0;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (elem_mem[mid] == target) begin
                    ans.found = 1'b1;
                    ans.index = mid[INDEX_W-1:0];
                    return ans;
                end
                if (elem_mem[mid] < target) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
            return ans;
        endfunction

        // Called for every request accepted on the input channel.
        function void note_request(op_t op, logic first, logic [VALUE_W-1:0] value);
            if (op == OP_LOAD) begin
                if (first) begin
                    elem_count = 0;
                end
                // A full table drops further elements.
                if (elem_count < DEPTH) begin
                    elem_mem[elem_count] = value;
                    elem_count++;
                end
            end else begin
                pending_answers.push_back(search_outcome(value));
            end
        endfunction

        task report(string what);
            $display("ERROR at %0t ns: %s", $time, what);
            mismatches++;
        endtask

        // Called for every result accepted on the output channel.
        task check_result(logic [M_TDATA_W-1:0] tdata);
            search_answer_t want;
            if (pending_answers.size() == 0) begin
                report($sformatf("result 0x%04h arrived with no search outstanding", tdata));
            end else begin
                want = pending_answers.pop_front();
                if (tdata[0] !== want.found) begin
                    report($sformatf("found flag %b, expected %b", tdata[0], want.found));
                end
                if (tdata[INDEX_W:1] !== want.index) begin
                    report($sformatf("index %0d, expected %0d", tdata[INDEX_W:1], want.index));
                end
            end
        endtask

        function int pending();
            return pending_answers.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;   // [30:0] value, [31] zero padding
    logic [S_TUSER_W-1:0]   s_axis_tuser;   // [0] operation, [1] first_element
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;   // [0] found, [10:1] index, [15:11] padding

    search_scoreboard sb = new();

    // Percentages of cycles in which the sender holds back and the receiver stalls.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned phase_requests = 0;

    sorted_table_binary_search_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The receiver decides at each falling edge whether it takes a result next cycle.
    always @(negedge aclk) begin
        m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Results are taken at the rising edge where valid and ready are both high.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
    end

    // Drives one request, starting at a falling edge, and returns at the falling edge
    // after it was accepted. Valid stays high when the next request follows at once.
    task automatic send_request(op_t op, logic first, logic [VALUE_W-1:0] value);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, value};
        s_axis_tuser  = {first, op};
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        sb.note_request(op, first, value);
        phase_requests++;
        @(negedge aclk);
    endtask

    // Holds the sender back until every search has been answered.
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // Loads n elements. With restart set, the first one carries first_element;
    // otherwise the elements are appended after the current last one. Ascending
    // tables grow by small steps when dense (so duplicates occur) or by wide steps.
    task automatic load_table(int n, bit restart, bit ascending, bit dense);
        int unsigned v;
        int unsigned span;
        if (!restart && sb.elem_count > 0) begin
            v = 32'(sb.elem_mem[sb.elem_count - 1]);
        end else if (dense) begin
            v = $urandom_range(0, VALUE_MAX);
        end else begin
            v = $urandom_range(0, 255);
        end
        span = dense ? 3 : (VALUE_MAX - v) / (n + 1) * 2;
        for (int i = 0; i < n; i++) begin
            if (!ascending) begin
                v = $urandom() & VALUE_MAX;
            end else if (i > 0 || !restart) begin
                v = v + $urandom_range(0, span);
                if (v > VALUE_MAX) begin
                    v = VALUE_MAX;
                end
            end
            send_request(OP_LOAD, restart && i == 0, v[VALUE_W-1:0]);
        end
    endtask

    // Searches for stored values, their neighbors, the extremes and random targets.
    // The first_element bit is random, since a search must ignore it.
    task automatic search_batch(int n);
        logic [VALUE_W-1:0] hit;
        logic [VALUE_W-1:0] tgt;
        for (int i = 0; i < n; i++) begin
            if (sb.elem_count > 0) begin
                hit = sb.elem_mem[$urandom_range(0, sb.elem_count - 1)];
            end else begin
                hit = VALUE_W'($urandom());
            end
            case ($urandom_range(0, 6))
                0, 1: begin
                    tgt = hit;
                end
                2: begin
                    tgt = hit + 1'b1;
                end
                3: begin
                    tgt = hit - 1'b1;
                end
                4: begin
                    tgt = '0;
                end
                5: begin
                    tgt = VALUE_MAX[VALUE_W-1:0];
                end
                default: begin
                    tgt = VALUE_W'($urandom());
                end
            endcase
            send_request(OP_SEARCH, 1'($urandom_range(0, 1)), tgt);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Directed requests, with neither side idling.
        // Searches of the empty table right after reset.
        send_request(OP_SEARCH, 1'b0, 31'd5);
        send_request(OP_SEARCH, 1'b1, 31'd0);
        // A single zero element, then the largest value appended.
        send_request(OP_LOAD, 1'b1, 31'd0);
        send_request(OP_SEARCH, 1'b0, 31'd0);
        send_request(OP_SEARCH, 1'b0, VALUE_MAX[VALUE_W-1:0]);
        send_request(OP_LOAD, 1'b0, VALUE_MAX[VALUE_W-1:0]);
        send_request(OP_SEARCH, 1'b0, VALUE_MAX[VALUE_W-1:0]);
        send_request(OP_SEARCH, 1'b0, VALUE_MAX[VALUE_W-2+1:0] - 1'b1);
        send_request(OP_LOAD, 1'b0, VALUE_MAX[VALUE_W-1:0]);
        send_request(OP_SEARCH, 1'b1, VALUE_MAX[VALUE_W-1:0]);
        // A restart over a table that is not in order: the answer follows the probes.
        send_request(OP_LOAD, 1'b1, 31'd1000);
        send_request(OP_LOAD, 1'b0, 31'd2000);
        send_request(OP_LOAD, 1'b0, 31'd3000);
        send_request(OP_LOAD, 1'b0, 31'd500);
        send_request(OP_SEARCH, 1'b0, 31'd1000);
        send_request(OP_SEARCH, 1'b0, 31'd3000);
        send_request(OP_SEARCH, 1'b0, 31'd500);
        send_request(OP_SEARCH, 1'b0, 31'd2000);
        send_request(OP_SEARCH, 1'b1, 31'd2500);
        send_request(OP_LOAD, 1'b1, 31'h4000_0000);
        send_request(OP_SEARCH, 1'b1, 31'h4000_0000);
        send_request(OP_SEARCH, 1'b0, 31'h3FFF_FFFF);
        wait_drained();

        // Random part in four idling phases: none, sender idle, receiver stalling, both.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = (p == 1) ? 51 : (p == 3) ? 12 : 0;
            recv_stall_pct = (p == 2) ? 51 : (p == 3) ? 12 : 0;
            phase_requests = 0;
            if (p == 0) begin
                // Fill the table past its capacity; the surplus loads are dropped.
                load_table(DEPTH + 6, 1'b1, 1'b1, 1'b0);
                send_request(OP_SEARCH, 1'b0, sb.elem_mem[DEPTH-1]);
                send_request(OP_SEARCH, 1'b0, sb.elem_mem[0]);
                send_request(OP_SEARCH, 1'b0, sb.elem_mem[DEPTH/2]);
                search_batch(40);
                phase_requests = 0;
            end
            while (phase_requests < 190) begin
                load_table($urandom_range(1, 40),
                           sb.elem_count > 900 || $urandom_range(0, 4) != 0,
                           $urandom_range(0, 9) != 0,
                           $urandom_range(0, 9) < 3);
                search_batch($urandom_range(2, 12));
            end
            // The sender pauses here until every search of the phase is answered.
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Ends a run that hangs; a correct run needs only a fraction of this.
    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
